### src/rtsu_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rtsu_pkg: route table insert/search shared definitions
// Field widths, status codes, register indexes and controller/datapath
// command and status bundles.
// ----------------------------------------------------------------------------
package rtsu_pkg;

    // Default table size, slot 0 included
    localparam int TABLE_SLOTS_DEF = 16;

    // Field widths
    localparam int ADDR_W   = 16;
    localparam int CHAN_W   = 8;
    localparam int KEY_W    = 2 * ADDR_W;
    localparam int HOPS_W   = 2 * ADDR_W + 2 * CHAN_W;
    localparam int ENTRY_W  = KEY_W + HOPS_W;
    localparam int STATUS_W = 3;
    localparam int SLOT_W   = 4;
    localparam int S_DATA_W = 80;
    localparam int M_DATA_W = 8;

    // Configuration port
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 16;
    localparam logic [CFG_IDX_W-1:0] REG_OWN_SOURCE      = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_OWN_DESTINATION = 1'b1;

    // Operation codes
    localparam logic OP_INSERT = 1'b0;
    localparam logic OP_SEARCH = 1'b1;

    // Result status codes
    localparam logic [STATUS_W-1:0] ST_INSERTED  = 3'd0;
    localparam logic [STATUS_W-1:0] ST_DUPLICATE = 3'd1;
    localparam logic [STATUS_W-1:0] ST_FULL      = 3'd2;
    localparam logic [STATUS_W-1:0] ST_FOUND     = 3'd3;
    localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 3'd4;

    // Controller to datapath
    typedef struct packed {
        logic start;   // latch request, restart scan
        logic scan;    // scan of stored routes in progress
        logic finish;  // commit result (and insert) this cycle
    } dp_cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic scan_end;  // match found or all stored routes compared
        logic out_free;  // result register can take a new result
    } dp_sts_t;

endpackage

### src/route_table_insert_search_unit.sv
`timescale 1ns / 1ps
// Each request scans the routes stored in the route RAM, one read per cycle;
//   a search stops early at the first match.
// One request is in work at a time, held by the route RAM scan; a new
//   request is taken while a result waits.
// Reset (aresetn, synchronous): clears the fill count, the own entry and the
//   result valid; RAM slots at or above the fill count read as empty.
// ----------------------------------------------------------------------------
// route_table_insert_search_unit: route table with insert and search
// Slot 0 is the node's own entry from configuration; slots 1 and up are
// filled in order by insert requests and scanned by both request kinds.
// ----------------------------------------------------------------------------
module route_table_insert_search_unit #(
    parameter int TABLE_SLOTS = rtsu_pkg::TABLE_SLOTS_DEF
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    // configuration write port
    input  logic                            cfg_wr_en,
    input  logic [rtsu_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [rtsu_pkg::CFG_DATA_W-1:0] cfg_wdata,
    // request channel
    input  logic                            s_tvalid,
    output logic                            s_tready,
    // source_addr, dest_addr, receive_hop, send_hop, receive_channel, send_channel
    input  logic [rtsu_pkg::S_DATA_W-1:0]   s_tdata,
    // operation
    input  logic                            s_tuser,
    // result channel
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // status, slot_index, zero pad
    output logic [rtsu_pkg::M_DATA_W-1:0]   m_tdata
);
    import rtsu_pkg::*;

    dp_cmd_t cmd;
    dp_sts_t sts;

    rtsu_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    rtsu_datapath #(
        .TABLE_SLOTS (TABLE_SLOTS)
    ) u_datapath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cmd       (cmd),
        .sts       (sts)
    );

    // one request in work at a time
    assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("request taken while busy");

    // a committed result is presented next cycle
    assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.finish |=> m_tvalid)
        else $error("result lost after commit");

    // status code in range
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[2:0] <= ST_NOT_FOUND))
        else $error("bad status code");

    // no slot reported without an insert or a find
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && ((m_tdata[2:0] == ST_DUPLICATE) || (m_tdata[2:0] == ST_FULL) ||
                      (m_tdata[2:0] == ST_NOT_FOUND))) |-> (m_tdata[6:3] == '0))
        else $error("slot index set without a slot");

endmodule

### src/rtsu_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rtsu_ram: generic single-write, single-read RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module rtsu_ram #(
    parameter int WIDTH  = 80,
    parameter int DEPTH  = 15,
    parameter int ADDR_W = 4
) (
    input  logic              aclk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [WIDTH-1:0]  wdata,
    input  logic [ADDR_W-1:0] raddr,
    output logic [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

### src/rtsu_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rtsu_ctrl: request sequencer
// Takes one request, runs the route scan, then commits the result.
// ----------------------------------------------------------------------------
module rtsu_ctrl (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_tvalid,
    output logic              s_tready,
    input  rtsu_pkg::dp_sts_t sts,
    output rtsu_pkg::dp_cmd_t cmd
);
    import rtsu_pkg::*;

    typedef enum logic [2:0] {
        IDLE   = 3'b001,
        SCAN   = 3'b010,
        FINISH = 3'b100
    } state_t;

    state_t state_reg, state_next;

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            IDLE: begin
                if (s_tvalid) begin
                    state_next = SCAN;
                end
            end
            SCAN: begin
                if (sts.scan_end) begin
                    state_next = FINISH;
                end
            end
            FINISH: begin
                if (sts.out_free) begin
                    state_next = IDLE;
                end
            end
            default: state_next = IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // commands
    assign s_tready   = (state_reg == IDLE);
    assign cmd.start  = (state_reg == IDLE) && s_tvalid;
    assign cmd.scan   = (state_reg == SCAN);
    assign cmd.finish = (state_reg == FINISH) && sts.out_free;

endmodule

### src/rtsu_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rtsu_datapath: route store, scan compare and result register
// Routes fill the store in order, so a fill count marks which slots are
// in use; slots at or above the count read as empty (all zero).
// ----------------------------------------------------------------------------
module rtsu_datapath #(
    parameter int TABLE_SLOTS = rtsu_pkg::TABLE_SLOTS_DEF
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              cfg_wr_en,
    input  logic [rtsu_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [rtsu_pkg::CFG_DATA_W-1:0]   cfg_wdata,
    input  logic [rtsu_pkg::S_DATA_W-1:0]     s_tdata,
    input  logic                              s_tuser,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [rtsu_pkg::M_DATA_W-1:0]     m_tdata,
    input  rtsu_pkg::dp_cmd_t                 cmd,
    output rtsu_pkg::dp_sts_t                 sts
);
    import rtsu_pkg::*;

    localparam int DEPTH = TABLE_SLOTS - 1;
    localparam int AW    = (TABLE_SLOTS > 2) ? $clog2(TABLE_SLOTS) : 1;
    localparam int NW    = AW + 1;                 // slot number width
    localparam int IW    = (NW > SLOT_W) ? NW : SLOT_W;
    localparam logic [AW-1:0] DEPTH_CNT = AW'(DEPTH);

    // request and configuration registers
    logic                op_reg;
    logic [ADDR_W-1:0]   src_reg, dst_reg;
    logic [HOPS_W-1:0]   hops_reg;
    logic [ADDR_W-1:0]   own_src_reg, own_dst_reg;

    // scan state
    logic [AW-1:0]       count_reg, count_next;
    logic [AW-1:0]       rd_idx_reg;
    logic [AW-1:0]       cmp_idx_reg;
    logic                cmp_vld_reg;
    logic                found_reg;
    logic [AW-1:0]       found_idx_reg;

    // result register
    logic                m_valid_reg, m_valid_next;
    logic [STATUS_W-1:0] m_status_reg, res_status;
    logic [SLOT_W-1:0]   m_slot_reg, res_slot;

    // RAM ports
    logic                ram_we;
    logic [ENTRY_W-1:0]  ram_wdata, ram_rdata;
    logic [KEY_W-1:0]    rd_key;

    logic                issue, hit, zero_key, room, own_match;
    logic [NW-1:0]       found_num, count_num;
    logic [IW-1:0]       found_ext, count_ext;

    function automatic logic key_match(input logic [ADDR_W-1:0] ks,
                                       input logic [ADDR_W-1:0] kd,
                                       input logic [ADDR_W-1:0] s,
                                       input logic [ADDR_W-1:0] d);
        return ((s == ks) && (d == kd)) || ((s == kd) && (d == ks));
    endfunction

    rtsu_ram #(
        .WIDTH  (ENTRY_W),
        .DEPTH  (DEPTH),
        .ADDR_W (AW)
    ) u_store (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (count_reg),
        .wdata (ram_wdata),
        .raddr (rd_idx_reg),
        .rdata (ram_rdata)
    );

    // entry: key (src high, dst low) above the hops
    assign ram_wdata = {src_reg, dst_reg, hops_reg};
    assign rd_key    = ram_rdata[ENTRY_W-1 -: KEY_W];

    // scan: one read issued per cycle, compared in the next cycle
    assign issue = cmd.scan && (rd_idx_reg != count_reg);
    assign hit   = cmd.scan && cmp_vld_reg && !found_reg &&
                   key_match(rd_key[KEY_W-1 -: ADDR_W], rd_key[ADDR_W-1:0],
                             src_reg, dst_reg);

    assign sts.scan_end = found_reg || ((rd_idx_reg == count_reg) && !cmp_vld_reg);
    assign sts.out_free = !m_valid_reg || m_tready;

    // result decision
    assign zero_key  = (src_reg == '0) && (dst_reg == '0);
    assign room      = (count_reg != DEPTH_CNT);
    assign own_match = key_match(own_src_reg, own_dst_reg, src_reg, dst_reg);
    assign found_num = {1'b0, found_idx_reg} + NW'(1);
    assign count_num = {1'b0, count_reg} + NW'(1);
    assign found_ext = IW'(found_num);
    assign count_ext = IW'(count_num);

    always_comb begin
        res_status = ST_NOT_FOUND;
        res_slot   = '0;
        if (op_reg == OP_INSERT) begin
            if (own_match || found_reg || (zero_key && room)) begin
                res_status = ST_DUPLICATE;
            end else if (room) begin
                res_status = ST_INSERTED;
                res_slot   = count_ext[SLOT_W-1:0];
            end else begin
                res_status = ST_FULL;
            end
        end else begin
            if (found_reg) begin
                res_status = ST_FOUND;
                res_slot   = found_ext[SLOT_W-1:0];
            end else if (zero_key && room) begin
                // first empty slot holds 0/0
                res_status = ST_FOUND;
                res_slot   = count_ext[SLOT_W-1:0];
            end
        end
    end

    assign ram_we     = cmd.finish && (op_reg == OP_INSERT) && (res_status == ST_INSERTED);
    assign count_next = ram_we ? count_reg + AW'(1) : count_reg;

    always_comb begin
        m_valid_next = m_valid_reg;
        if (cmd.finish) begin
            m_valid_next = 1'b1;
        end else if (m_tready) begin
            m_valid_next = 1'b0;
        end
    end

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg   <= '0;
            own_src_reg <= '0;
            own_dst_reg <= '0;
            m_valid_reg <= 1'b0;
            cmp_vld_reg <= 1'b0;
            found_reg   <= 1'b0;
            rd_idx_reg  <= '0;
        end else begin
            count_reg   <= count_next;
            m_valid_reg <= m_valid_next;
            if (cfg_wr_en && (cfg_index == REG_OWN_SOURCE)) begin
                own_src_reg <= cfg_wdata;
            end
            if (cfg_wr_en && (cfg_index == REG_OWN_DESTINATION)) begin
                own_dst_reg <= cfg_wdata;
            end
            if (cmd.start) begin
                rd_idx_reg  <= '0;
                cmp_vld_reg <= 1'b0;
                found_reg   <= 1'b0;
            end else begin
                cmp_vld_reg <= issue;
                if (issue) begin
                    rd_idx_reg <= rd_idx_reg + AW'(1);
                end
                if (hit) begin
                    found_reg <= 1'b1;
                end
            end
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        if (cmd.start) begin
            op_reg   <= s_tuser;
            src_reg  <= s_tdata[15:0];
            dst_reg  <= s_tdata[31:16];
            // receive_hop, send_hop, receive_channel, send_channel, high to low
            hops_reg <= {s_tdata[47:32], s_tdata[63:48], s_tdata[71:64], s_tdata[79:72]};
        end
        if (issue) begin
            cmp_idx_reg <= rd_idx_reg;
        end
        if (hit) begin
            found_idx_reg <= cmp_idx_reg;
        end
        if (cmd.finish) begin
            m_status_reg <= res_status;
            m_slot_reg   <= res_slot;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {1'b0, m_slot_reg, m_status_reg};

endmodule

### tb/sv/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for the route table insert/search unit
// Streams insert and search requests into the table, mirrors the table and
// the own entry in a scoreboard, and checks every status/slot result in order.
// A directed burst covers empty-slot matching, swapped keys and the own entry;
// random phases then fill the table to full under varying idle and stall rates.
// ----------------------------------------------------------------------------
module tb_top;
    import rtsu_pkg::*;

    localparam int STORE_DEPTH  = TABLE_SLOTS_DEF - 1;
    localparam int CYCLE_LIMIT  = 600000;
    localparam int PHASE_ITEMS  = 420;
    localparam int REPORT_LIMIT = 10;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [SLOT_W-1:0]   slot;
    } route_answer_t;

    // Mirror of the route table; predicts one answer per accepted request
    class route_table_scoreboard;
        logic [ADDR_W-1:0] own_src;
        logic [ADDR_W-1:0] own_dst;
        logic [KEY_W-1:0]  route_key [STORE_DEPTH];
        logic [HOPS_W-1:0] route_hop [STORE_DEPTH];
        route_answer_t     awaited [$];
        int                stored;
        int                n_requests;
        int                n_results;
        int                n_errors;
        int                n_status [5];

        function new();
            own_src    = '0;
            own_dst    = '0;
            stored     = 0;
            n_requests = 0;
            n_results  = 0;
            n_errors   = 0;
            foreach (route_key[i]) begin
                route_key[i] = '0;
                route_hop[i] = '0;
            end
            foreach (n_status[i]) n_status[i] = 0;
        endfunction

        // key matches in either direction
        function bit key_hit(logic [KEY_W-1:0] key, logic [ADDR_W-1:0] s,
                             logic [ADDR_W-1:0] d);
            return (key == {s, d}) || (key == {d, s});
        endfunction

        // apply one request to the mirror and queue its answer
        function void note_request(logic op, logic [ADDR_W-1:0] s,
                                   logic [ADDR_W-1:0] d, logic [HOPS_W-1:0] hops);
            route_answer_t ans;
            bit            done;
            int            i;
            ans.slot = '0;
            done     = 0;
            if (op == OP_INSERT) begin
                done = key_hit({own_src, own_dst}, s, d);
                for (i = 0; i < STORE_DEPTH; i++)
                    if (key_hit(route_key[i], s, d)) done = 1;
                if (done) begin
                    ans.status = ST_DUPLICATE;
                end else begin
                    ans.status = ST_FULL;
                    for (i = 0; i < STORE_DEPTH && !done; i++) begin
                        // empty means key and hops all zero
                        if (route_key[i] == '0 && route_hop[i] == '0) begin
                            route_key[i] = {s, d};
                            route_hop[i] = hops;
                            ans.status   = ST_INSERTED;
                            ans.slot     = SLOT_W'(i + 1);
                            stored++;
                            done = 1;
                        end
                    end
                end
            end else begin
                // search skips the own entry; empty slots hold key 0/0
                ans.status = ST_NOT_FOUND;
                for (i = 0; i < STORE_DEPTH && !done; i++) begin
                    if (key_hit(route_key[i], s, d)) begin
                        ans.status = ST_FOUND;
                        ans.slot   = SLOT_W'(i + 1);
                        done = 1;
                    end
                end
            end
            awaited.push_back(ans);
            n_requests++;
        endfunction

        // compare one result transfer with the oldest answer
        function void check_result(logic [STATUS_W-1:0] st, logic [SLOT_W-1:0] sl);
            route_answer_t exp_ans;
            n_results++;
            if (awaited.size() == 0) begin
                n_errors++;
                if (n_errors <= REPORT_LIMIT)
                    $display("ERROR: result %0d with nothing awaited: status %0d slot %0d",
                             n_results, st, sl);
                return;
            end
            exp_ans = awaited.pop_front();
            if (st !== exp_ans.status || sl !== exp_ans.slot) begin
                n_errors++;
                if (n_errors <= REPORT_LIMIT)
                    $display("ERROR: result %0d: expected status %0d slot %0d, got %0d %0d",
                             n_results, exp_ans.status, exp_ans.slot, st, sl);
            end else begin
                n_status[exp_ans.status]++;
            end
        endfunction
    endclass

    logic                  aclk = 1'b0;
    logic                  aresetn;
    logic                  cfg_wr_en;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_wdata;
    logic                  s_tvalid;
    logic                  s_tready;
    // source_addr, dest_addr, receive_hop, send_hop, receive_channel, send_channel
    logic [S_DATA_W-1:0]   s_tdata;
    // operation
    logic                  s_tuser;
    logic                  m_tvalid;
    logic                  m_tready;
    // status, slot_index, zero pad
    logic [M_DATA_W-1:0]   m_tdata;

    route_table_scoreboard table_model;
    int                    idle_pct  = 0;
    int                    stall_pct = 0;
    int                    cycle_count = 0;

    route_table_insert_search_unit #(
        .TABLE_SLOTS(TABLE_SLOTS_DEF)
    ) dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    always #5 aclk = ~aclk;

    // watchdog
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("ERROR: timeout after %0d cycles, %0d answers outstanding",
                     cycle_count, table_model.awaited.size());
            $display("status: fail");
            $finish;
        end
    end

    // result side: check each transfer, then pick the next ready level
    initial begin
        m_tready <= 1'b0;
        forever begin
            @(posedge aclk);
            if (aresetn === 1'b1 && m_tvalid === 1'b1 && m_tready === 1'b1)
                table_model.check_result(m_tdata[STATUS_W-1:0],
                                         m_tdata[STATUS_W+SLOT_W-1:STATUS_W]);
            m_tready <= ($urandom_range(99) >= stall_pct);
        end
    end

    // one request transfer, with random idle cycles in front
    task automatic send_request(input logic op, input logic [ADDR_W-1:0] s,
                                input logic [ADDR_W-1:0] d, input logic [ADDR_W-1:0] rh,
                                input logic [ADDR_W-1:0] sh, input logic [CHAN_W-1:0] rc,
                                input logic [CHAN_W-1:0] sc);
        while ($urandom_range(99) < idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= {sc, rc, sh, rh, d, s};
        do @(posedge aclk); while (s_tready !== 1'b1);
        table_model.note_request(op, s, d, {rh, sh, rc, sc});
    endtask

    // hold off the sender until every answer is back
    task automatic drain_results();
        s_tvalid <= 1'b0;
        while (table_model.awaited.size() != 0) @(posedge aclk);
    endtask

    // write both own-entry registers; only called while idle
    task automatic set_own_entry(input logic [ADDR_W-1:0] src,
                                 input logic [ADDR_W-1:0] dst);
        cfg_wr_en <= 1'b1;
        cfg_index <= REG_OWN_SOURCE;
        cfg_wdata <= src;
        @(posedge aclk);
        cfg_index <= REG_OWN_DESTINATION;
        cfg_wdata <= dst;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        table_model.own_src = src;
        table_model.own_dst = dst;
    endtask

    // random request, biased toward keys the table already holds
    task automatic random_request();
        int                pick;
        int                n;
        logic              op;
        logic [ADDR_W-1:0] s;
        logic [ADDR_W-1:0] d;
        logic [ADDR_W-1:0] rh;
        logic [ADDR_W-1:0] sh;
        logic [CHAN_W-1:0] rc;
        logic [CHAN_W-1:0] sc;
        n    = table_model.stored;
        pick = $urandom_range(99);
        op   = 1'($urandom_range(1));
        s    = ADDR_W'($urandom);
        d    = ADDR_W'($urandom);
        if (pick < 40 && n > 0) begin
            op     = OP_SEARCH;
            {s, d} = table_model.route_key[$urandom_range(n - 1)];
        end else if (pick < 55 && n > 0) begin
            op     = OP_INSERT;
            {s, d} = table_model.route_key[$urandom_range(n - 1)];
        end else if (pick < 60) begin
            {s, d} = {table_model.own_src, table_model.own_dst};
        end else if (pick < 64) begin
            op = OP_INSERT;
        end else if (pick < 69) begin
            {s, d} = '0;
        end else if (pick < 80) begin
            // tiny address space: collisions and swapped pairs
            s = ADDR_W'($urandom_range(3));
            d = ADDR_W'($urandom_range(3));
        end
        if ($urandom_range(1)) {s, d} = {d, s};
        rh   = ADDR_W'($urandom);
        sh   = ADDR_W'($urandom);
        rc   = CHAN_W'($urandom);
        sc   = CHAN_W'($urandom);
        pick = $urandom_range(99);
        if (pick < 5)
            {rh, sh, rc, sc} = '0;
        else if (pick < 10)
            {rh, sh, rc, sc} = '1;
        send_request(op, s, d, rh, sh, rc, sc);
    endtask

    // stimulus
    initial begin
        int phase;
        table_model = new();
        aresetn   <= 1'b0;
        cfg_wr_en <= 1'b0;
        cfg_index <= '0;
        cfg_wdata <= '0;
        s_tvalid  <= 1'b0;
        s_tuser   <= 1'b0;
        s_tdata   <= '0;
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;

        // own entry at its reset value 0/0; empty slots match 0/0
        send_request(OP_SEARCH, 16'h0000, 16'h0000, 16'hFFFF, 16'hFFFF, 8'hFF, 8'hFF);
        send_request(OP_SEARCH, 16'h1234, 16'h5678, 16'h0000, 16'h0000, 8'h00, 8'h00);
        send_request(OP_INSERT, 16'h0000, 16'h0000, 16'hFFFF, 16'hFFFF, 8'hFF, 8'hFF);
        send_request(OP_INSERT, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 8'hFF, 8'hFF);
        send_request(OP_SEARCH, 16'hFFFF, 16'hFFFF, 16'h0000, 16'h0000, 8'h00, 8'h00);
        // zero hops with a nonzero key still occupies the slot
        send_request(OP_INSERT, 16'h0001, 16'h8000, 16'h0000, 16'h0000, 8'h00, 8'h00);
        send_request(OP_INSERT, 16'h8000, 16'h0001, 16'h1234, 16'h4321, 8'h5A, 8'hA5);
        send_request(OP_SEARCH, 16'h8000, 16'h0001, 16'hBEEF, 16'hCAFE, 8'h81, 8'h18);
        drain_results();

        // own entry takes part in the duplicate check but not in search
        set_own_entry(16'hFFFF, 16'h0000);
        send_request(OP_INSERT, 16'h0000, 16'hFFFF, 16'h0101, 16'h1010, 8'h01, 8'h10);
        send_request(OP_INSERT, 16'hFFFF, 16'h0000, 16'h0101, 16'h1010, 8'h01, 8'h10);
        send_request(OP_SEARCH, 16'hFFFF, 16'h0000, 16'h0000, 16'h0000, 8'h00, 8'h00);
        send_request(OP_SEARCH, 16'h0000, 16'h0000, 16'h7FFF, 16'h8000, 8'h7F, 8'h80);
        send_request(OP_INSERT, 16'h5555, 16'hAAAA, 16'h0000, 16'hFFFF, 8'h00, 8'hFF);
        send_request(OP_INSERT, 16'hAAAA, 16'h5555, 16'hFFFF, 16'h0000, 8'hFF, 8'h00);
        send_request(OP_SEARCH, 16'hAAAA, 16'h5555, 16'h1111, 16'h2222, 8'h33, 8'h44);
        send_request(OP_SEARCH, 16'h0001, 16'h0001, 16'h0000, 16'h0000, 8'h00, 8'h00);
        drain_results();

        // random phases: idle/stall mode and own entry change between phases
        for (phase = 0; phase < 4; phase++) begin
            case (phase)
                0: begin
                    idle_pct = 0;  stall_pct = 0;
                    set_own_entry(ADDR_W'($urandom), ADDR_W'($urandom));
                end
                1: begin
                    idle_pct = 58; stall_pct = 0;
                    set_own_entry(16'hFFFF, 16'hFFFF);
                end
                2: begin
                    idle_pct = 0;  stall_pct = 58;
                    set_own_entry(16'h0000, 16'h0000);
                end
                default: begin
                    idle_pct = 21; stall_pct = 21;
                    set_own_entry(ADDR_W'($urandom), ADDR_W'($urandom));
                end
            endcase
            repeat (PHASE_ITEMS) random_request();
            drain_results();
        end
        stall_pct = 0;
        repeat (30) @(posedge aclk);

        $display("Covered %0d requests over 4 idle/stall modes and 6 own-entry settings",
                 table_model.n_requests);
        $display("Matched: inserted %0d, duplicate %0d, full %0d, found %0d, not found %0d",
                 table_model.n_status[ST_INSERTED], table_model.n_status[ST_DUPLICATE],
                 table_model.n_status[ST_FULL], table_model.n_status[ST_FOUND],
                 table_model.n_status[ST_NOT_FOUND]);
        if (table_model.n_errors == 0 && table_model.awaited.size() == 0) begin
            $display("status: pass");
        end else begin
            $display("ERROR: %0d mismatches, %0d answers never arrived",
                     table_model.n_errors, table_model.awaited.size());
            $display("status: fail");
        end
        $finish;
    end

endmodule
